// ===== sv/foc_dq_current_pi_regulator_macros.svh =====
// -----------------------------------------------------------------------------
// dq current regulator assertion macros
// Concurrent checks on the rising clock edge, off while reset is asserted.
// -----------------------------------------------------------------------------
`ifndef FOC_DQ_CURRENT_PI_REGULATOR_MACROS_SVH
`define FOC_DQ_CURRENT_PI_REGULATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FOC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed: %m");

// Consequent must hold in the cycle after the antecedent.
`define FOC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed: %m");

`endif

// ===== sv/foc_dq_pkg.sv =====
// -----------------------------------------------------------------------------
// dq current regulator package
// Widths, register codes, the quarter-wave sine table and shared fixed-point
// helpers.
// -----------------------------------------------------------------------------
package foc_dq_pkg;

  // Quarter-wave sine table: SINE_TABLE_DEPTH + 1 entries over 0..90 degrees.
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int SINE_MAG_W       = 13;
  localparam int TRIG_W           = 14;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  // (2n)(2n+1) for the Taylor terms n = 1..8
  localparam logic [7:0][8:0] TAYLOR_DIV = {9'd272, 9'd210, 9'd156, 9'd110,
                                            9'd72,  9'd42,  9'd20,  9'd6};

  // Shared multiplier and datapath widths.
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = 30;
  localparam int P_W     = 33;
  localparam int SUM_W   = 18;
  localparam int BETA_W  = 17;
  localparam int ERR_W   = 17;

  localparam logic signed [MUL_B_W-1:0] INV_SQRT3_Q15 = 18'sd18919;
  localparam logic signed [PROD_W-1:0]  SAT_MAX       = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0]  SAT_MIN       = -PROD_W'(32768);

  // Configuration port.
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int GAIN_W      = 16;
  localparam int LIMIT_W     = 15;
  localparam int VAL_W       = 16;
  localparam int ANGLE_W     = 12;

  localparam logic [GAIN_W-1:0]        PROP_GAIN_RST   = 16'd256;
  localparam logic [GAIN_W-1:0]        INTEG_GAIN_RST  = 16'd0;
  localparam logic [LIMIT_W-1:0]       INTEG_LIMIT_RST = 15'd3686;
  localparam logic signed [VAL_W-1:0]  D_REF_RST       = 16'sd0;
  localparam logic signed [VAL_W-1:0]  Q_REF_RST       = 16'sd2867;

  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 12'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN   = 3'd0,
    CFG_INTEG_GAIN  = 3'd1,
    CFG_INTEG_LIMIT = 3'd2,
    CFG_D_REF       = 3'd3,
    CFG_Q_REF       = 3'd4
  } cfg_idx_e;

  typedef logic [SINE_TABLE_DEPTH:0][SINE_MAG_W-1:0] sine_rom_t;

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    longint      sum;
    longint      v;
    rom = '0;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = (HALF_PI_Q30 * 64'(k)) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 8; n++) begin
        term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[n-1]);
        if ((n & 1) != 0) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (sum + (longint'(1) <<< 17)) >>> 18;
      if (v > 4096) begin
        v = 4096;
      end
      rom[k] = SINE_MAG_W'(v);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // Sine of a 12-bit angle, 4096 = 1.0.
  function automatic logic signed [TRIG_W-1:0] sine_lookup(input logic [ANGLE_W-1:0] angle);
    logic [1:0]            quad;
    logic [9:0]            pos;
    logic [10:0]           u;
    logic [SINE_IDX_W-1:0] idx;
    logic [SINE_MAG_W-1:0] mag;
    quad = angle[11:10];
    pos  = angle[9:0];
    u    = quad[0] ? (11'd1024 - {1'b0, pos}) : {1'b0, pos};
    idx  = SINE_IDX_W'((32'(u) * SINE_TABLE_DEPTH) >> 10);
    mag  = SINE_ROM[idx];
    return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  // Add half an LSB, then floor shift.
  function automatic logic signed [PROD_W-1:0] rnd_shr(input logic signed [PROD_W-1:0] v,
                                                       input int unsigned sh);
    logic signed [PROD_W-1:0] half;
    half = $signed(PROD_W'(1)) <<< (sh - 1);
    return (v + half) >>> sh;
  endfunction

  function automatic logic signed [VAL_W-1:0] sat16(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] c;
    if (v > SAT_MAX) begin
      c = SAT_MAX;
    end else if (v < SAT_MIN) begin
      c = SAT_MIN;
    end else begin
      c = v;
    end
    return VAL_W'(c);
  endfunction

  typedef enum logic [2:0] {
    MA_SUM, MA_ALPHA, MA_BETA, MA_ERR, MA_PROD, MA_VD, MA_VQ
  } mul_a_e;

  typedef enum logic [2:0] {
    MB_INV_SQRT3, MB_SIN, MB_COS, MB_KP, MB_KI
  } mul_b_e;

  // One step of the sequencer, as seen by the datapath.
  typedef struct packed {
    mul_a_e mul_a;
    mul_b_e mul_b;
    logic   ld_sin;
    logic   ld_cos;
    logic   ld_beta;
    logic   ld_acc;
    logic   ld_id;
    logic   ld_iq;
    logic   ld_va;
    logic   ld_vb;
    logic   cmb_sub;
    logic   err_on_q;
    logic   pi_on_q;
    logic   ld_p;
    logic   ld_integ;
    logic   ld_v;
  } ctl_t;

endpackage

// ===== sv/foc_dq_dp.sv =====
// -----------------------------------------------------------------------------
// dq current regulator datapath
// Shared multiplier with product register, accumulator, sine lookup and the
// working registers of one item.
// -----------------------------------------------------------------------------
module foc_dq_dp (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  foc_dq_pkg::ctl_t                         ctl_i,
  input  logic                                     start_i,
  input  logic signed [foc_dq_pkg::VAL_W-1:0]      phase_a_i,
  input  logic signed [foc_dq_pkg::VAL_W-1:0]      phase_b_i,
  input  logic        [foc_dq_pkg::ANGLE_W-1:0]    angle_i,
  input  logic        [foc_dq_pkg::GAIN_W-1:0]     prop_gain_i,
  input  logic        [foc_dq_pkg::GAIN_W-1:0]     integ_gain_i,
  input  logic        [foc_dq_pkg::LIMIT_W-1:0]    integ_limit_i,
  input  logic signed [foc_dq_pkg::VAL_W-1:0]      d_ref_i,
  input  logic signed [foc_dq_pkg::VAL_W-1:0]      q_ref_i,
  output logic signed [foc_dq_pkg::VAL_W-1:0]      id_o,
  output logic signed [foc_dq_pkg::VAL_W-1:0]      iq_o,
  output logic signed [foc_dq_pkg::VAL_W-1:0]      vd_o,
  output logic signed [foc_dq_pkg::VAL_W-1:0]      vq_o,
  output logic signed [foc_dq_pkg::VAL_W-1:0]      va_o,
  output logic signed [foc_dq_pkg::VAL_W-1:0]      vb_o
);
  import foc_dq_pkg::*;

  logic signed [VAL_W-1:0]   alpha_q;
  logic signed [SUM_W-1:0]   sum_q;
  logic [ANGLE_W-1:0]        ang_q;
  logic signed [TRIG_W-1:0]  sin_q, cos_q;
  logic signed [BETA_W-1:0]  beta_q;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic signed [ACC_W-1:0]   acc_q;
  logic signed [P_W-1:0]     p_q;
  logic signed [VAL_W-1:0]   id_q, iq_q, vd_q, vq_q, va_q, vb_q;
  logic signed [VAL_W-1:0]   integ_d_q, integ_q_q;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [ERR_W-1:0]   err;
  logic signed [VAL_W-1:0]   ref_sel, meas_sel, integ_sel;
  logic [ANGLE_W-1:0]        look_ang;
  logic signed [TRIG_W-1:0]  look_val;
  logic signed [PROD_W-1:0]  cmb_sum, cmb_res;
  logic signed [PROD_W-1:0]  integ_sum, lim_x, integ_clamp;
  logic signed [PROD_W-1:0]  v_sum;
  logic signed [PROD_W-1:0]  beta_full;

  // Error of the selected axis
  assign ref_sel  = ctl_i.err_on_q ? q_ref_i : d_ref_i;
  assign meas_sel = ctl_i.err_on_q ? iq_q : id_q;
  assign err      = ERR_W'(ref_sel) - ERR_W'(meas_sel);

  always_comb begin
    unique case (ctl_i.mul_a)
      MA_SUM:   mul_a = MUL_A_W'(sum_q);
      MA_ALPHA: mul_a = MUL_A_W'(alpha_q);
      MA_BETA:  mul_a = MUL_A_W'(beta_q);
      MA_ERR:   mul_a = MUL_A_W'(err);
      MA_PROD:  mul_a = $signed(prod_q[MUL_A_W-1:0]);
      MA_VD:    mul_a = MUL_A_W'(vd_q);
      MA_VQ:    mul_a = MUL_A_W'(vq_q);
      default:  mul_a = '0;
    endcase
  end

  always_comb begin
    unique case (ctl_i.mul_b)
      MB_INV_SQRT3: mul_b = INV_SQRT3_Q15;
      MB_SIN:       mul_b = MUL_B_W'(sin_q);
      MB_COS:       mul_b = MUL_B_W'(cos_q);
      MB_KP:        mul_b = $signed({2'b00, prop_gain_i});
      MB_KI:        mul_b = $signed({2'b00, integ_gain_i});
      default:      mul_b = '0;
    endcase
  end

  assign prod_d = mul_a * mul_b;

  // One table read per cycle: sine first, cosine a quarter turn later
  assign look_ang = ctl_i.ld_cos ? (ang_q + QUARTER_TURN) : ang_q;
  assign look_val = sine_lookup(look_ang);

  assign beta_full = rnd_shr(prod_q, 15);

  // Rotation combine: accumulated product plus or minus the current one
  assign cmb_sum = ctl_i.cmb_sub ? (PROD_W'(acc_q) - prod_q) : (PROD_W'(acc_q) + prod_q);
  assign cmb_res = rnd_shr(cmb_sum, 12);

  // Integrator step and clamp
  assign integ_sel = ctl_i.pi_on_q ? integ_q_q : integ_d_q;
  assign integ_sum = PROD_W'(integ_sel) + rnd_shr(prod_q, 16);
  assign lim_x     = PROD_W'($signed({1'b0, integ_limit_i}));

  always_comb begin
    if (integ_sum > lim_x) begin
      integ_clamp = lim_x;
    end else if (integ_sum < -lim_x) begin
      integ_clamp = -lim_x;
    end else begin
      integ_clamp = integ_sum;
    end
  end

  assign v_sum = PROD_W'(integ_sel) + rnd_shr(PROD_W'(p_q), 8);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_d_q <= '0;
      integ_q_q <= '0;
    end else if (ctl_i.ld_integ) begin
      if (ctl_i.pi_on_q) begin
        integ_q_q <= VAL_W'(integ_clamp);
      end else begin
        integ_d_q <= VAL_W'(integ_clamp);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (start_i) begin
      alpha_q <= phase_a_i;
      sum_q   <= SUM_W'(phase_a_i) + (SUM_W'(phase_b_i) <<< 1);
      ang_q   <= angle_i;
    end
    if (ctl_i.ld_sin)  sin_q  <= look_val;
    if (ctl_i.ld_cos)  cos_q  <= look_val;
    if (ctl_i.ld_beta) beta_q <= BETA_W'(beta_full);
    if (ctl_i.ld_acc)  acc_q  <= ACC_W'(prod_q);
    if (ctl_i.ld_p)    p_q    <= P_W'(prod_q);
    if (ctl_i.ld_id)   id_q   <= sat16(cmb_res);
    if (ctl_i.ld_iq)   iq_q   <= sat16(cmb_res);
    if (ctl_i.ld_va)   va_q   <= sat16(cmb_res);
    if (ctl_i.ld_vb)   vb_q   <= sat16(cmb_res);
    if (ctl_i.ld_v) begin
      if (ctl_i.pi_on_q) begin
        vq_q <= sat16(v_sum);
      end else begin
        vd_q <= sat16(v_sum);
      end
    end
  end

  assign id_o = id_q;
  assign iq_o = iq_q;
  assign vd_o = vd_q;
  assign vq_o = vq_q;
  assign va_o = va_q;
  assign vb_o = vb_q;

endmodule

// ===== sv/foc_dq_seq.sv =====
// -----------------------------------------------------------------------------
// dq current regulator sequencer
// One-hot step machine that drives the shared multiplier and the datapath
// register loads for one item.
// -----------------------------------------------------------------------------
module foc_dq_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              out_free_i,
  output logic              ready_o,
  output logic              done_o,
  output foc_dq_pkg::ctl_t  ctl_o
);
  import foc_dq_pkg::*;

  typedef enum logic [17:0] {
    ST_IDLE = 18'h00001,
    ST_SIN  = 18'h00002,
    ST_COS  = 18'h00004,
    ST_BETA = 18'h00008,
    ST_D0   = 18'h00010,
    ST_D1   = 18'h00020,
    ST_Q0   = 18'h00040,
    ST_Q1   = 18'h00080,
    ST_DP   = 18'h00100,
    ST_DI   = 18'h00200,
    ST_DV   = 18'h00400,
    ST_QI   = 18'h00800,
    ST_QV   = 18'h01000,
    ST_A0   = 18'h02000,
    ST_A1   = 18'h04000,
    ST_B0   = 18'h08000,
    ST_B1   = 18'h10000,
    ST_DONE = 18'h20000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_SIN;
      end
      ST_SIN: begin
        ctl_o.ld_sin = 1'b1;
        state_d      = ST_COS;
      end
      ST_COS: begin
        ctl_o.ld_cos = 1'b1;
        ctl_o.mul_a  = MA_SUM;
        ctl_o.mul_b  = MB_INV_SQRT3;
        state_d      = ST_BETA;
      end
      ST_BETA: begin
        ctl_o.ld_beta = 1'b1;
        ctl_o.mul_a   = MA_ALPHA;
        ctl_o.mul_b   = MB_COS;
        state_d       = ST_D0;
      end
      ST_D0: begin
        ctl_o.ld_acc = 1'b1;
        ctl_o.mul_a  = MA_BETA;
        ctl_o.mul_b  = MB_SIN;
        state_d      = ST_D1;
      end
      ST_D1: begin
        ctl_o.ld_id = 1'b1;
        ctl_o.mul_a = MA_BETA;
        ctl_o.mul_b = MB_COS;
        state_d     = ST_Q0;
      end
      ST_Q0: begin
        ctl_o.ld_acc = 1'b1;
        ctl_o.mul_a  = MA_ALPHA;
        ctl_o.mul_b  = MB_SIN;
        state_d      = ST_Q1;
      end
      ST_Q1: begin
        ctl_o.ld_iq   = 1'b1;
        ctl_o.cmb_sub = 1'b1;
        ctl_o.mul_a   = MA_ERR;
        ctl_o.mul_b   = MB_KP;
        state_d       = ST_DP;
      end
      ST_DP: begin
        ctl_o.ld_p  = 1'b1;
        ctl_o.mul_a = MA_PROD;
        ctl_o.mul_b = MB_KI;
        state_d     = ST_DI;
      end
      ST_DI: begin
        ctl_o.ld_integ = 1'b1;
        ctl_o.err_on_q = 1'b1;
        ctl_o.mul_a    = MA_ERR;
        ctl_o.mul_b    = MB_KP;
        state_d        = ST_DV;
      end
      ST_DV: begin
        ctl_o.ld_v  = 1'b1;
        ctl_o.ld_p  = 1'b1;
        ctl_o.mul_a = MA_PROD;
        ctl_o.mul_b = MB_KI;
        state_d     = ST_QI;
      end
      ST_QI: begin
        ctl_o.ld_integ = 1'b1;
        ctl_o.pi_on_q  = 1'b1;
        ctl_o.mul_a    = MA_VD;
        ctl_o.mul_b    = MB_COS;
        state_d        = ST_QV;
      end
      ST_QV: begin
        ctl_o.ld_v    = 1'b1;
        ctl_o.pi_on_q = 1'b1;
        ctl_o.ld_acc  = 1'b1;
        state_d       = ST_A0;
      end
      ST_A0: begin
        ctl_o.mul_a = MA_VQ;
        ctl_o.mul_b = MB_SIN;
        state_d     = ST_A1;
      end
      ST_A1: begin
        ctl_o.ld_va   = 1'b1;
        ctl_o.cmb_sub = 1'b1;
        ctl_o.mul_a   = MA_VD;
        ctl_o.mul_b   = MB_SIN;
        state_d       = ST_B0;
      end
      ST_B0: begin
        ctl_o.ld_acc = 1'b1;
        ctl_o.mul_a  = MA_VQ;
        ctl_o.mul_b  = MB_COS;
        state_d      = ST_B1;
      end
      ST_B1: begin
        ctl_o.ld_vb = 1'b1;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        if (out_free_i) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign ready_o = (state_q == ST_IDLE);
  assign done_o  = (state_q == ST_DONE) && out_free_i;

endmodule

// ===== sv/foc_dq_current_pi_regulator.sv =====
// -----------------------------------------------------------------------------
// Field-oriented dq current PI regulator
// Takes two phase current samples and the electrical angle, runs Clarke and
// Park transforms, a clamped PI loop on each of the d and q axes and the
// inverse Park transform, and returns the measured d/q currents, the d/q
// voltage commands and the saturated alpha/beta voltages, all signed Q3.12.
// Each item passes through 16 sequencer steps, 13 of which run one after
// another through a single 33x18 signed multiplier with a product register,
// then a hand-over step and the idle state in which the next item is
// accepted. The sine and cosine come from a 1025-entry quarter-wave table
// read once per cycle into a register. in_stall_o is high while an item is
// in work; the finished result sits in an output register, so the next
// item is taken while it waits, and the hand-over stalls only while that
// register is still full. Write configuration only while idle.
// -----------------------------------------------------------------------------
`include "foc_dq_current_pi_regulator_macros.svh"

module foc_dq_current_pi_regulator (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  // input items
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic signed [foc_dq_pkg::VAL_W-1:0]      phase_a_current_i,
  input  logic signed [foc_dq_pkg::VAL_W-1:0]      phase_b_current_i,
  input  logic        [foc_dq_pkg::ANGLE_W-1:0]    elec_angle_i,
  // result items
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic signed [foc_dq_pkg::VAL_W-1:0]      d_current_o,
  output logic signed [foc_dq_pkg::VAL_W-1:0]      q_current_o,
  output logic signed [foc_dq_pkg::VAL_W-1:0]      d_voltage_o,
  output logic signed [foc_dq_pkg::VAL_W-1:0]      q_voltage_o,
  output logic signed [foc_dq_pkg::VAL_W-1:0]      alpha_voltage_o,
  output logic signed [foc_dq_pkg::VAL_W-1:0]      beta_voltage_o,
  // configuration writes
  input  logic                                     cfg_we_i,
  input  logic        [foc_dq_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic        [foc_dq_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import foc_dq_pkg::*;

  // Configuration registers
  logic [GAIN_W-1:0]        prop_gain_q;
  logic [GAIN_W-1:0]        integ_gain_q;
  logic [LIMIT_W-1:0]       integ_limit_q;
  logic signed [VAL_W-1:0]  d_ref_q;
  logic signed [VAL_W-1:0]  q_ref_q;

  // Sequencer and datapath hookup
  ctl_t                     ctl;
  logic                     seq_ready;
  logic                     seq_done;
  logic                     in_accept;
  logic                     out_free;
  logic signed [VAL_W-1:0]  id, iq, vd, vq, va, vb;

  // Output register
  logic                     out_valid_q;
  logic signed [VAL_W-1:0]  d_current_q, q_current_q;
  logic signed [VAL_W-1:0]  d_voltage_q, q_voltage_q;
  logic signed [VAL_W-1:0]  alpha_voltage_q, beta_voltage_q;

  // Take a new item only from idle; hold stall for the whole computation.
  assign in_stall_o = !seq_ready;
  assign in_accept  = in_valid_i && seq_ready;

  // The output register is free when empty or being drained this cycle.
  assign out_free = !out_valid_q || !out_stall_i;

  // Register writes; unknown indexes drop silently.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q   <= PROP_GAIN_RST;
      integ_gain_q  <= INTEG_GAIN_RST;
      integ_limit_q <= INTEG_LIMIT_RST;
      d_ref_q       <= D_REF_RST;
      q_ref_q       <= Q_REF_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PROP_GAIN:   prop_gain_q   <= cfg_data_i[GAIN_W-1:0];
        CFG_INTEG_GAIN:  integ_gain_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_INTEG_LIMIT: integ_limit_q <= cfg_data_i[LIMIT_W-1:0];
        CFG_D_REF:       d_ref_q       <= $signed(cfg_data_i[VAL_W-1:0]);
        CFG_Q_REF:       q_ref_q       <= $signed(cfg_data_i[VAL_W-1:0]);
        default:         ;
      endcase
    end
  end

  foc_dq_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_accept),
    .out_free_i (out_free),
    .ready_o    (seq_ready),
    .done_o     (seq_done),
    .ctl_o      (ctl)
  );

  foc_dq_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .start_i       (in_accept),
    .phase_a_i     (phase_a_current_i),
    .phase_b_i     (phase_b_current_i),
    .angle_i       (elec_angle_i),
    .prop_gain_i   (prop_gain_q),
    .integ_gain_i  (integ_gain_q),
    .integ_limit_i (integ_limit_q),
    .d_ref_i       (d_ref_q),
    .q_ref_i       (q_ref_q),
    .id_o          (id),
    .iq_o          (iq),
    .vd_o          (vd),
    .vq_o          (vq),
    .va_o          (va),
    .vb_o          (vb)
  );

  // Result hand-over: set valid on completion, drop it once taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seq_done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq_done) begin
      d_current_q     <= id;
      q_current_q     <= iq;
      d_voltage_q     <= vd;
      q_voltage_q     <= vq;
      alpha_voltage_q <= va;
      beta_voltage_q  <= vb;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign d_current_o     = d_current_q;
  assign q_current_o     = q_current_q;
  assign d_voltage_o     = d_voltage_q;
  assign q_voltage_o     = q_voltage_q;
  assign alpha_voltage_o = alpha_voltage_q;
  assign beta_voltage_o  = beta_voltage_q;

  // An accepted item keeps the block busy and cannot finish in the next cycle.
  `FOC_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, in_accept, in_stall_o && !seq_done)
  // A result completes only while the input side is stalled.
  `FOC_ASSERT_SAME(a_done_busy, clk_i, rst_ni, seq_done, in_stall_o)
  // A completed result never overwrites one that is still waiting.
  `FOC_ASSERT_SAME(a_done_free, clk_i, rst_ni, seq_done, !out_valid_q || !out_stall_i)

endmodule
